@@ rtl/core/oscmd_pkg.sv @@
// ----------------------------------------------------------------------------
// oscmd_pkg
// Shared types, codes and constant strings of the OSC message decoder.
// ----------------------------------------------------------------------------
package oscmd_pkg;

    // Default sizes
    localparam int PACKET_BYTES   = 256;
    localparam int NAME_CHARS     = 16;
    localparam int SPECTRUM_BANDS = 32;
    localparam int MAX_RESULTS    = 64;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LAYOUT_MODE = 2'd0,
        CFG_NAME_FIRST  = 2'd1,
        CFG_NAME_SECOND = 2'd2,
        CFG_NAME_LENGTH = 2'd3
    } t_cfg_idx;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_FLOAT   = 2'd1,
        KIND_ADDR    = 2'd2,
        KIND_TEXT    = 2'd3
    } t_kind;

    // Message classes
    typedef enum logic [2:0] {
        MT_LAYOUT     = 3'd0,
        MT_LAYOUT_TXT = 3'd1,
        MT_XY         = 3'd2,
        MT_FADER      = 3'd3,
        MT_BUTTON     = 3'd4,
        MT_NOTE       = 3'd5,
        MT_SPECTRUM   = 3'd6,
        MT_BACKGROUND = 3'd7
    } t_mtype;

    // Endpoint names matched after the device prefix
    typedef enum logic [2:0] {
        LIT_XY0,
        LIT_NOTE,
        LIT_SPECTRUM,
        LIT_BACKGROUND,
        LIT_FADER,
        LIT_BUTTON
    } t_lit;

    localparam logic [127:0] STR_XY0        = {"xy0", 104'd0};
    localparam logic [127:0] STR_NOTE       = {"note", 96'd0};
    localparam logic [127:0] STR_SPECTRUM   = {"spectrum0", 56'd0};
    localparam logic [127:0] STR_BACKGROUND = {"background", 48'd0};
    localparam logic [127:0] STR_FADER      = {"fader", 88'd0};
    localparam logic [127:0] STR_BUTTON     = {"button", 80'd0};

    localparam logic [3:0] LEN_XY0        = 4'd3;
    localparam logic [3:0] LEN_NOTE       = 4'd4;
    localparam logic [3:0] LEN_SPECTRUM   = 4'd9;
    localparam logic [3:0] LEN_BACKGROUND = 4'd10;
    localparam logic [3:0] LEN_FADER      = 4'd5;
    localparam logic [3:0] LEN_BUTTON     = 4'd6;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;

    // Float limits
    localparam logic [31:0] FLOAT_ONE      = 32'h3F80_0000;
    localparam logic [31:0] FLOAT_NEG_ZERO = 32'h8000_0000;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic         layout_mode;
        logic [127:0] name_chars;
        logic [4:0]   name_length;
    } t_cfg;

    // One result beat
    typedef struct packed {
        t_kind       kind;
        logic        accepted;
        logic [2:0]  message_type;
        logic [6:0]  index;
        logic        int_value;
        logic [5:0]  value_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [63:0] payload;
        logic [3:0]  payload_bytes;
        logic        last;
    } t_result;

    // Character k of an endpoint name
    function automatic logic [7:0] lit_byte(input t_lit id, input logic [3:0] k);
        logic [127:0] s;
        begin
            case (id)
                LIT_XY0:        s = STR_XY0;
                LIT_NOTE:       s = STR_NOTE;
                LIT_SPECTRUM:   s = STR_SPECTRUM;
                LIT_BACKGROUND: s = STR_BACKGROUND;
                LIT_FADER:      s = STR_FADER;
                LIT_BUTTON:     s = STR_BUTTON;
                default:        s = '0;
            endcase
            lit_byte = s[(127 - 8 * k) -: 8];
        end
    endfunction

endpackage

@@ rtl/core/oscmd_ram.sv @@
// ----------------------------------------------------------------------------
// oscmd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module oscmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/oscmd_seq.sv @@
// ----------------------------------------------------------------------------
// oscmd_seq
// Parse and emit sequencer: walks the packet store through its read port,
// scans address, type tags and arguments, then streams the result beats.
// ----------------------------------------------------------------------------
module oscmd_seq #(
    parameter int PACKET_BYTES   = oscmd_pkg::PACKET_BYTES,
    parameter int NAME_CHARS     = oscmd_pkg::NAME_CHARS,
    parameter int SPECTRUM_BANDS = oscmd_pkg::SPECTRUM_BANDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(PACKET_BYTES+1)-1:0] i_len,
    input  oscmd_pkg::t_cfg                   i_cfg,
    output logic [$clog2(PACKET_BYTES)-1:0]   o_rd_addr,
    input  logic [7:0]                        i_rd_data,
    output logic                              o_busy,
    output logic                              o_strobe,
    output oscmd_pkg::t_result                o_res
);

    localparam int AW = $clog2(PACKET_BYTES);
    localparam int CW = $clog2(PACKET_BYTES + 1);
    localparam int PW = CW + 1;
    localparam int NW = oscmd_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ADDR, S_TAG, S_DECIDE, S_ARGS, S_TEXT,
        S_VERDICT, S_FLOAT, S_CHUNK, S_REJECT, S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        C_NONE, C_FLOAT, C_TEXT, C_BUTTON, C_NOTE, C_BG
    } t_cls;

    t_state  r_state;
    logic    r_ph;
    logic [PW-1:0] r_ptr, r_len, r_sbase, r_al, r_tl, r_off;
    logic [PW-1:0] r_a0, r_alen, r_x0, r_xlen, r_crem;
    logic    r_slash, r_devok, r_comma, r_allf, r_alli, r_alls;
    logic    r_mxy, r_mnote, r_mspec, r_mbg, r_mfad, r_mbut;
    logic [7:0]  r_dig5, r_dig6;
    t_cls    r_cls;
    logic [2:0]  r_mtype;
    logic [5:0]  r_nw, r_vcount, r_wi, r_fi;
    logic [6:0]  r_idx;
    logic        r_intv, r_hasaddr, r_hastext;
    logic [7:0]  r_red, r_green, r_blue;
    logic [1:0]  r_bi;
    logic [31:0] r_word;
    oscmd_pkg::t_kind r_seg;
    logic [2:0]  r_nb;
    logic [63:0] r_acc;
    logic [NW-1:0] r_cnt;
    oscmd_pkg::t_result r_pend, r_out;
    logic    r_pv, r_strobe;

    // String scan helpers
    logic [PW-1:0] w_slen, w_pad, w_rl, w_k, w_pm1, w_el, w_skip;
    logic [4:0]    w_nl;
    logic [3:0]    w_k4;
    logic          w_kv, w_name_bad;
    logic [7:0]    w_b;

    assign w_b    = i_rd_data;
    assign w_slen = r_ptr - r_sbase;
    assign w_pad  = r_sbase + ((w_slen + PW'(4)) & ~PW'(3));
    assign w_nl   = (i_cfg.name_length > 5'(NAME_CHARS)) ? 5'(NAME_CHARS) : i_cfg.name_length;
    assign w_rl   = PW'(w_nl) + PW'(2);
    assign w_k    = r_ptr - w_rl;
    assign w_kv   = (r_ptr >= w_rl) && (w_k < PW'(16));
    assign w_k4   = w_k[3:0];
    assign w_pm1  = r_ptr - PW'(1);
    assign w_name_bad = (r_ptr >= PW'(1)) && (r_ptr <= PW'(w_nl)) &&
                        (w_b != i_cfg.name_chars[(127 - 8 * w_pm1[3:0]) -: 8]);

    // Message classification
    logic   w_dev, w_tf, w_tff, w_ts, w_ti, w_tii, w_tiii, w_spec;
    t_cls   w_cls;
    logic [2:0] w_mt;
    logic [5:0] w_nw;
    logic   w_addr, w_text, w_useskip;
    logic [6:0] w_idx;

    assign w_dev  = r_devok && (r_al >= w_rl);
    assign w_el   = r_al - w_rl;
    assign w_skip = w_dev ? (w_rl - PW'(1)) : '0;
    assign w_tf   = (r_tl == PW'(2)) && r_allf;
    assign w_tff  = (r_tl == PW'(3)) && r_allf;
    assign w_ts   = (r_tl == PW'(2)) && r_alls;
    assign w_ti   = (r_tl == PW'(2)) && r_alli;
    assign w_tii  = (r_tl == PW'(3)) && r_alli;
    assign w_tiii = (r_tl == PW'(4)) && r_alli;
    assign w_spec = (r_tl == PW'(SPECTRUM_BANDS + 1)) && r_allf;

    always_comb begin
        w_cls = C_NONE;
        w_mt = oscmd_pkg::MT_LAYOUT;
        w_nw = '0;
        w_addr = 1'b0;
        w_text = 1'b0;
        w_useskip = 1'b0;
        w_idx = '0;
        if (i_cfg.layout_mode && (w_tf || w_tff) && r_slash) begin
            w_cls = C_FLOAT;
            w_nw = w_tff ? 6'd2 : 6'd1;
            w_addr = 1'b1;
            w_useskip = 1'b1;
        end else if (i_cfg.layout_mode && w_ts && r_slash) begin
            w_cls = C_TEXT;
            w_mt = oscmd_pkg::MT_LAYOUT_TXT;
            w_addr = 1'b1;
            w_text = 1'b1;
            w_useskip = 1'b1;
        end else if (w_dev && w_tff && r_mxy && w_el == PW'(oscmd_pkg::LEN_XY0)) begin
            w_cls = C_FLOAT;
            w_mt = oscmd_pkg::MT_XY;
            w_nw = 6'd2;
        end else if (w_dev && w_tf && r_mfad && w_el == PW'(6) &&
                     (r_dig5 inside {[oscmd_pkg::CH_0:oscmd_pkg::CH_3]})) begin
            w_cls = C_FLOAT;
            w_mt = oscmd_pkg::MT_FADER;
            w_nw = 6'd1;
            w_idx = 7'(r_dig5 - oscmd_pkg::CH_0);
        end else if (w_dev && w_ti && r_mbut && w_el == PW'(7) &&
                     (r_dig6 inside {[oscmd_pkg::CH_0:oscmd_pkg::CH_3]})) begin
            w_cls = C_BUTTON;
            w_mt = oscmd_pkg::MT_BUTTON;
            w_nw = 6'd1;
            w_idx = 7'(r_dig6 - oscmd_pkg::CH_0);
        end else if (w_dev && (w_tii || w_tiii) && r_mnote &&
                     w_el == PW'(oscmd_pkg::LEN_NOTE)) begin
            w_cls = C_NOTE;
            w_mt = oscmd_pkg::MT_NOTE;
            w_nw = w_tiii ? 6'd3 : 6'd2;
        end else if (w_dev && w_spec && r_mspec && w_el == PW'(oscmd_pkg::LEN_SPECTRUM)) begin
            w_cls = C_FLOAT;
            w_mt = oscmd_pkg::MT_SPECTRUM;
            w_nw = 6'(SPECTRUM_BANDS);
        end else if (w_dev && w_tiii && r_mbg && w_el == PW'(oscmd_pkg::LEN_BACKGROUND)) begin
            w_cls = C_BG;
            w_mt = oscmd_pkg::MT_BACKGROUND;
            w_nw = 6'd3;
        end else if ((w_tf || w_tff) && r_slash) begin
            w_cls = C_FLOAT;
            w_nw = w_tff ? 6'd2 : 6'd1;
            w_addr = 1'b1;
        end else if (w_ts && r_slash) begin
            w_cls = C_TEXT;
            w_mt = oscmd_pkg::MT_LAYOUT_TXT;
            w_addr = 1'b1;
            w_text = 1'b1;
        end
    end

    // Argument word check
    logic [31:0] w_word;
    logic        w_word_ok;

    assign w_word = {r_word[23:0], w_b};

    always_comb begin
        case (r_cls)
            C_FLOAT:  w_word_ok = (w_word <= oscmd_pkg::FLOAT_ONE) ||
                                  (w_word == oscmd_pkg::FLOAT_NEG_ZERO);
            C_BUTTON: w_word_ok = (w_word <= 32'd1);
            C_NOTE:   w_word_ok = (r_wi == 6'd1) ? (w_word <= 32'd1) : (w_word <= 32'd127);
            C_BG:     w_word_ok = (w_word <= 32'd255);
            default:  w_word_ok = 1'b0;
        endcase
    end

    // Result beat formation
    logic               w_form;
    oscmd_pkg::t_result w_new;
    logic [63:0]        w_acc;

    always_comb begin
        w_form = 1'b0;
        w_new = '0;
        w_acc = r_acc;
        w_acc[(63 - 8 * r_nb) -: 8] = w_b;
        case (r_state)
            S_REJECT: begin
                w_form = 1'b1;
            end
            S_VERDICT: begin
                w_form = 1'b1;
                w_new.kind = oscmd_pkg::KIND_VERDICT;
                w_new.accepted = 1'b1;
                w_new.message_type = r_mtype;
                w_new.index = r_idx;
                w_new.int_value = r_intv;
                w_new.value_count = r_vcount;
                w_new.red = r_red;
                w_new.green = r_green;
                w_new.blue = r_blue;
            end
            S_FLOAT: begin
                if (r_ph && r_bi == 2'd3) begin
                    w_form = 1'b1;
                    w_new.kind = oscmd_pkg::KIND_FLOAT;
                    w_new.payload = {32'd0, w_word};
                end
            end
            S_CHUNK: begin
                if (r_ph && (r_nb == 3'd7 || r_crem == PW'(1))) begin
                    w_form = 1'b1;
                    w_new.kind = r_seg;
                    w_new.payload = w_acc;
                    w_new.payload_bytes = {1'b0, r_nb} + 4'd1;
                end
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 1'b0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_len   <= PW'(i_len);
                        r_ptr   <= '0;
                        r_sbase <= '0;
                        r_ph    <= 1'b0;
                        r_cnt   <= '0;
                        r_slash <= 1'b0;
                        r_devok <= 1'b1;
                        r_mxy   <= 1'b1;
                        r_mnote <= 1'b1;
                        r_mspec <= 1'b1;
                        r_mbg   <= 1'b1;
                        r_mfad  <= 1'b1;
                        r_mbut  <= 1'b1;
                        r_dig5  <= '0;
                        r_dig6  <= '0;
                        r_comma <= 1'b0;
                        r_allf  <= 1'b1;
                        r_alli  <= 1'b1;
                        r_alls  <= 1'b1;
                        r_idx   <= '0;
                        r_intv  <= 1'b0;
                        r_red   <= '0;
                        r_green <= '0;
                        r_blue  <= '0;
                        r_state <= S_ADDR;
                    end
                end

                // Address string: prefix and endpoint name matching
                S_ADDR: begin
                    if (!r_ph) begin
                        if (r_ptr >= r_len) r_state <= S_REJECT;
                        else r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (w_b == oscmd_pkg::CH_NUL) begin
                            r_al <= r_ptr;
                            if (w_pad > r_len) begin
                                r_state <= S_REJECT;
                            end else begin
                                r_ptr   <= w_pad;
                                r_sbase <= w_pad;
                                r_state <= S_TAG;
                            end
                        end else begin
                            r_ptr <= r_ptr + PW'(1);
                            if (r_ptr == '0) begin
                                r_slash <= (w_b == oscmd_pkg::CH_SLASH);
                                if (w_b != oscmd_pkg::CH_SLASH) r_devok <= 1'b0;
                            end
                            if (w_name_bad) r_devok <= 1'b0;
                            if (r_ptr == w_rl - PW'(1) && w_b != oscmd_pkg::CH_SLASH) begin
                                r_devok <= 1'b0;
                            end
                            if (w_kv) begin
                                if (w_k4 < oscmd_pkg::LEN_XY0 &&
                                    w_b != oscmd_pkg::lit_byte(oscmd_pkg::LIT_XY0, w_k4))
                                    r_mxy <= 1'b0;
                                if (w_k4 < oscmd_pkg::LEN_NOTE &&
                                    w_b != oscmd_pkg::lit_byte(oscmd_pkg::LIT_NOTE, w_k4))
                                    r_mnote <= 1'b0;
                                if (w_k4 < oscmd_pkg::LEN_SPECTRUM &&
                                    w_b != oscmd_pkg::lit_byte(oscmd_pkg::LIT_SPECTRUM, w_k4))
                                    r_mspec <= 1'b0;
                                if (w_k4 < oscmd_pkg::LEN_BACKGROUND &&
                                    w_b != oscmd_pkg::lit_byte(oscmd_pkg::LIT_BACKGROUND, w_k4))
                                    r_mbg <= 1'b0;
                                if (w_k4 < oscmd_pkg::LEN_FADER &&
                                    w_b != oscmd_pkg::lit_byte(oscmd_pkg::LIT_FADER, w_k4))
                                    r_mfad <= 1'b0;
                                if (w_k4 < oscmd_pkg::LEN_BUTTON &&
                                    w_b != oscmd_pkg::lit_byte(oscmd_pkg::LIT_BUTTON, w_k4))
                                    r_mbut <= 1'b0;
                                if (w_k4 == 4'd5) r_dig5 <= w_b;
                                if (w_k4 == 4'd6) r_dig6 <= w_b;
                            end
                        end
                    end
                end

                // Type-tag string
                S_TAG: begin
                    if (!r_ph) begin
                        if (r_ptr >= r_len) r_state <= S_REJECT;
                        else r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (w_b == oscmd_pkg::CH_NUL) begin
                            r_tl  <= w_slen;
                            r_off <= w_pad;
                            if (w_slen == '0 || w_pad > r_len) r_state <= S_REJECT;
                            else r_state <= S_DECIDE;
                        end else begin
                            r_ptr <= r_ptr + PW'(1);
                            if (w_slen == '0) begin
                                r_comma <= (w_b == oscmd_pkg::CH_COMMA);
                            end else begin
                                if (w_b != oscmd_pkg::CH_F) r_allf <= 1'b0;
                                if (w_b != oscmd_pkg::CH_I) r_alli <= 1'b0;
                                if (w_b != oscmd_pkg::CH_S) r_alls <= 1'b0;
                            end
                        end
                    end
                end

                // Classification
                S_DECIDE: begin
                    if (!r_comma || w_cls == C_NONE) begin
                        r_state <= S_REJECT;
                    end else begin
                        r_cls     <= w_cls;
                        r_mtype   <= w_mt;
                        r_nw      <= w_nw;
                        r_vcount  <= (w_cls == C_FLOAT) ? w_nw : 6'd0;
                        r_idx     <= w_idx;
                        r_hasaddr <= w_addr;
                        r_hastext <= w_text;
                        r_a0      <= w_useskip ? w_skip : '0;
                        r_alen    <= r_al - (w_useskip ? w_skip : '0);
                        r_xlen    <= '0;
                        r_ptr     <= r_off;
                        r_sbase   <= r_off;
                        r_wi      <= '0;
                        r_bi      <= '0;
                        r_state   <= (w_cls == C_TEXT) ? S_TEXT : S_ARGS;
                    end
                end

                // Argument words, checked one by one
                S_ARGS: begin
                    if (!r_ph) begin
                        if (r_wi == r_nw) r_state <= S_VERDICT;
                        else if (r_bi == 2'd0 && r_ptr + PW'(4) > r_len) r_state <= S_REJECT;
                        else r_ph <= 1'b1;
                    end else begin
                        r_ph   <= 1'b0;
                        r_word <= w_word;
                        r_ptr  <= r_ptr + PW'(1);
                        r_bi   <= r_bi + 2'd1;
                        if (r_bi == 2'd3) begin
                            if (!w_word_ok) begin
                                r_state <= S_REJECT;
                            end else begin
                                r_wi <= r_wi + 6'd1;
                                if (r_cls == C_BUTTON) r_intv <= w_word[0];
                                if (r_cls == C_NOTE && r_wi == 6'd0) r_idx <= w_word[6:0];
                                if (r_cls == C_NOTE && r_wi == 6'd1) r_intv <= w_word[0];
                                if (r_cls == C_BG && r_wi == 6'd0) r_red <= w_word[7:0];
                                if (r_cls == C_BG && r_wi == 6'd1) r_green <= w_word[7:0];
                                if (r_cls == C_BG && r_wi == 6'd2) r_blue <= w_word[7:0];
                            end
                        end
                    end
                end

                // Text argument string
                S_TEXT: begin
                    if (!r_ph) begin
                        if (r_ptr >= r_len) r_state <= S_REJECT;
                        else r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (w_b == oscmd_pkg::CH_NUL) begin
                            r_x0   <= r_sbase;
                            r_xlen <= w_slen;
                            r_state <= (w_pad > r_len) ? S_REJECT : S_VERDICT;
                        end else begin
                            r_ptr <= r_ptr + PW'(1);
                        end
                    end
                end

                S_VERDICT: begin
                    r_ptr   <= r_off;
                    r_fi    <= '0;
                    r_bi    <= '0;
                    r_state <= S_FLOAT;
                end

                // Float words re-read from the store
                S_FLOAT: begin
                    if (!r_ph) begin
                        if (r_fi == r_vcount) begin
                            r_nb  <= '0;
                            r_acc <= '0;
                            if (r_hasaddr) begin
                                r_ptr   <= r_a0;
                                r_crem  <= r_alen;
                                r_seg   <= oscmd_pkg::KIND_ADDR;
                                r_state <= S_CHUNK;
                            end else if (r_hastext) begin
                                r_ptr   <= r_x0;
                                r_crem  <= r_xlen;
                                r_seg   <= oscmd_pkg::KIND_TEXT;
                                r_state <= S_CHUNK;
                            end else begin
                                r_state <= S_FLUSH;
                            end
                        end else if (r_cnt == NW'(oscmd_pkg::MAX_RESULTS)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        r_ph   <= 1'b0;
                        r_word <= w_word;
                        r_ptr  <= r_ptr + PW'(1);
                        r_bi   <= r_bi + 2'd1;
                        if (r_bi == 2'd3) r_fi <= r_fi + 6'd1;
                    end
                end

                // Address and text chunks of up to eight characters
                S_CHUNK: begin
                    if (!r_ph) begin
                        if (r_crem == '0) begin
                            if (r_seg == oscmd_pkg::KIND_ADDR && r_hastext) begin
                                r_ptr  <= r_x0;
                                r_crem <= r_xlen;
                                r_seg  <= oscmd_pkg::KIND_TEXT;
                            end else begin
                                r_state <= S_FLUSH;
                            end
                        end else if (r_nb == 3'd0 &&
                                     r_cnt == NW'(oscmd_pkg::MAX_RESULTS)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        r_ph   <= 1'b0;
                        r_ptr  <= r_ptr + PW'(1);
                        r_crem <= r_crem - PW'(1);
                        r_acc  <= w_form ? 64'd0 : w_acc;
                        r_nb   <= w_form ? 3'd0 : r_nb + 3'd1;
                    end
                end

                S_REJECT: begin
                    r_state <= S_FLUSH;
                end

                // Last beat leaves with the end mark
                S_FLUSH: begin
                    r_out      <= r_pend;
                    r_out.last <= 1'b1;
                    r_strobe   <= 1'b1;
                    r_pv       <= 1'b0;
                    r_state    <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase

            // One beat held back so that the final one can carry last
            if (w_form) begin
                if (r_pv) begin
                    r_out    <= r_pend;
                    r_strobe <= 1'b1;
                end
                r_pend <= w_new;
                r_pv   <= 1'b1;
                r_cnt  <= r_cnt + NW'(1);
            end
        end
    end

    assign o_rd_addr = r_ptr[AW-1:0];
    assign o_busy    = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_res     = r_out;

    // Checks
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_out.last |=> !r_strobe)
        else $error("beat directly after the final beat of a packet");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(oscmd_pkg::MAX_RESULTS))
        else $error("result count beyond cap");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pv)
        else $error("held beat left behind when idle");

    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_out.kind == oscmd_pkg::KIND_VERDICT && !r_out.accepted |-> r_out.last)
        else $error("rejection verdict not final");

endmodule

@@ rtl/core/osc_packet_message_decoder.sv @@
// ----------------------------------------------------------------------------
// osc_packet_message_decoder
// OSC message decoder top level: packet store loading, configuration
// registers and the parse/emit sequencer.
// ----------------------------------------------------------------------------
// A byte without the end mark is taken while start is high and busy is low. After the end
// byte, the packet is walked through the store's single read port (address issue, then
// registered read), then beats are streamed. No packet bytes are taken while busy is high.
// Results leave one per strobe, unstallable; busy covers parse and all beats but the last.
// Reset (synchronous): byte count, sequencer and configuration clear; the store
// itself is not cleared.
module osc_packet_message_decoder #(
    parameter int PACKET_BYTES   = oscmd_pkg::PACKET_BYTES,
    parameter int NAME_CHARS     = oscmd_pkg::NAME_CHARS,
    parameter int SPECTRUM_BANDS = oscmd_pkg::SPECTRUM_BANDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_end_of_packet,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic        o_accepted,
    output logic [2:0]  o_message_type,
    output logic [6:0]  o_index,
    output logic        o_int_value,
    output logic [5:0]  o_value_count,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [63:0] o_payload,
    output logic [3:0]  o_payload_bytes,
    output logic        o_last
);

    localparam int AW = $clog2(PACKET_BYTES);
    localparam int CW = $clog2(PACKET_BYTES + 1);

    logic          r_layout;
    logic [63:0]   r_name_first, r_name_second;
    logic [4:0]    r_name_len;
    logic [CW-1:0] r_bcnt;

    logic          w_accept, w_fits, w_start, w_busy;
    logic [CW-1:0] w_len;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;
    oscmd_pkg::t_cfg    w_cfg;
    oscmd_pkg::t_result w_res;

    assign w_accept = start && !w_busy;
    assign w_fits   = (r_bcnt < CW'(PACKET_BYTES));
    assign w_len    = r_bcnt + CW'(w_fits);
    assign w_start  = w_accept && i_end_of_packet;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout      <= 1'b0;
            r_name_first  <= '0;
            r_name_second <= '0;
            r_name_len    <= '0;
        end else if (i_cfg_valid) begin
            case (oscmd_pkg::t_cfg_idx'(i_cfg_index))
                oscmd_pkg::CFG_LAYOUT_MODE: r_layout      <= i_cfg_data[0];
                oscmd_pkg::CFG_NAME_FIRST:  r_name_first  <= i_cfg_data;
                oscmd_pkg::CFG_NAME_SECOND: r_name_second <= i_cfg_data;
                oscmd_pkg::CFG_NAME_LENGTH: r_name_len    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Byte count; overlong packets drop the excess
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else if (w_accept) begin
            r_bcnt <= i_end_of_packet ? '0 : w_len;
        end
    end

    assign w_cfg.layout_mode = r_layout;
    assign w_cfg.name_chars  = {r_name_first, r_name_second};
    assign w_cfg.name_length = r_name_len;

    oscmd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_fits),
        .i_wr_addr (r_bcnt[AW-1:0]),
        .i_wr_data (i_packet_byte),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    oscmd_seq #(
        .PACKET_BYTES   (PACKET_BYTES),
        .NAME_CHARS     (NAME_CHARS),
        .SPECTRUM_BANDS (SPECTRUM_BANDS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_len     (w_len),
        .i_cfg     (w_cfg),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_busy    (w_busy),
        .o_strobe  (o_strobe),
        .o_res     (w_res)
    );

    assign busy            = w_busy;
    assign o_cfg_ready     = 1'b1;
    assign o_kind          = w_res.kind;
    assign o_accepted      = w_res.accepted;
    assign o_message_type  = w_res.message_type;
    assign o_index         = w_res.index;
    assign o_int_value     = w_res.int_value;
    assign o_value_count   = w_res.value_count;
    assign o_red           = w_res.red;
    assign o_green         = w_res.green;
    assign o_blue          = w_res.blue;
    assign o_payload       = w_res.payload;
    assign o_payload_bytes = w_res.payload_bytes;
    assign o_last          = w_res.last;

endmodule

@@ tb/sv/tb_osc_packet_message_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_osc_packet_message_decoder
// Byte-level test of the OSC message decoder. Packets of every message class,
// valid and broken, are built byte by byte and pushed in with random gaps or
// in bursts. A built-in predictor works out the verdict, float and chunk
// beats of each packet, and a checker compares every result beat.
// ----------------------------------------------------------------------------
module tb_osc_packet_message_decoder;
    import oscmd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 700;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_BYTES  = 360;
    localparam int RANDOM_PKTS   = 40;

    // Clock, reset and block signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_packet_byte = 8'd0;
    logic        i_end_of_packet = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [63:0] i_cfg_data = 64'd0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic        o_accepted;
    logic [2:0]  o_message_type;
    logic [6:0]  o_index;
    logic        o_int_value;
    logic [5:0]  o_value_count;
    logic [7:0]  o_red, o_green, o_blue;
    logic [63:0] o_payload;
    logic [3:0]  o_payload_bytes;
    logic        o_last;

    osc_packet_message_decoder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_packet_byte(i_packet_byte), .i_end_of_packet(i_end_of_packet),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_kind(o_kind), .o_accepted(o_accepted),
        .o_message_type(o_message_type), .o_index(o_index),
        .o_int_value(o_int_value), .o_value_count(o_value_count),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue),
        .o_payload(o_payload), .o_payload_bytes(o_payload_bytes), .o_last(o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Decoded message as the predictor sees it
    typedef struct {
        t_mtype      mtype;
        int unsigned idx, ival, cnt, red, green, blue;
        int unsigned fpos, addr0, addrlen, text0, textlen;
        bit          has_addr, has_text;
    } msg_info_t;

    // Predictor state: register copies and the packet buffer
    logic        cfg_layout;
    logic [63:0] cfg_first, cfg_second;
    logic [4:0]  cfg_len;
    logic [7:0]  pkt_mem [0:PACKET_BYTES-1];
    int unsigned pkt_fill, pkt_len;
    t_result     beats_due[$];

    // Stimulus state
    logic [7:0]  pk[$];
    bit          burst;
    int          n_errors, n_packets, n_bytes, n_beats, n_accepted, n_configs;
    int          cycles;
    t_result     beat_exp;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit scan_str(inout int unsigned off, output int unsigned st,
                                    output int unsigned sl);
        int unsigned o, e;
        o = off;
        st = 0;
        sl = 0;
        if (o >= pkt_len) return 0;
        e = o;
        while (e < pkt_len && pkt_mem[e] != CH_NUL) e++;
        if (e == pkt_len) return 0;
        st = o;
        sl = e - o;
        off = o + ((e - o + 4) & ~32'd3);
        return off <= pkt_len;
    endfunction

    function automatic bit same_str(int unsigned pos, int unsigned len, string lit);
        if (lit.len() != len) return 0;
        for (int i = 0; i < lit.len(); i++)
            if (pkt_mem[pos + i] != lit[i]) return 0;
        return 1;
    endfunction

    function automatic bit fetch_word(int unsigned pos, output int unsigned w);
        w = 0;
        if (pos > pkt_len || pkt_len - pos < 4) return 0;
        w = {pkt_mem[pos], pkt_mem[pos + 1], pkt_mem[pos + 2], pkt_mem[pos + 3]};
        return 1;
    endfunction

    function automatic bit unit_ok(int unsigned pos, int unsigned n);
        int unsigned w;
        for (int i = 0; i < n; i++) begin
            if (!fetch_word(pos + 4 * i, w)) return 0;
            if (!(w <= FLOAT_ONE || w == FLOAT_NEG_ZERO)) return 0;
        end
        return 1;
    endfunction

    function automatic logic [7:0] name_chr(int unsigned i);
        if (i < 8) return cfg_first[63 - 8 * i -: 8];
        return cfg_second[63 - 8 * (i - 8) -: 8];
    endfunction

    function automatic bit float_class(ref msg_info_t m, input t_mtype t,
                                       input int unsigned off, n);
        m.mtype = t;
        m.cnt   = n;
        m.fpos  = off;
        return unit_ok(off, n);
    endfunction

    function automatic bit classify(ref msg_info_t m);
        int unsigned off, a0, al, t0, tl, nl, rl, ep, el, skip, w, v, mn;
        bit dev, slash, tf, tff, ts, ti, tii, tiii, spec;
        m = '{mtype: MT_LAYOUT, default: 0};
        off = 0;
        ep = 0;
        el = 0;
        dev = 0;
        if (!scan_str(off, a0, al) || !scan_str(off, t0, tl)) return 0;
        if (tl == 0 || pkt_mem[t0] != CH_COMMA) return 0;
        nl = (cfg_len > NAME_CHARS) ? NAME_CHARS : cfg_len;
        rl = nl + 2;
        // device prefix: slash, name, slash
        if (al >= rl && pkt_mem[a0] == CH_SLASH && pkt_mem[a0 + rl - 1] == CH_SLASH) begin
            dev = 1;
            for (int i = 0; i < nl; i++)
                if (pkt_mem[a0 + 1 + i] != name_chr(i)) dev = 0;
        end
        if (dev) begin
            ep = a0 + rl;
            el = al - rl;
        end
        slash = al > 0 && pkt_mem[a0] == CH_SLASH;
        tf    = same_str(t0, tl, ",f");
        tff   = same_str(t0, tl, ",ff");
        ts    = same_str(t0, tl, ",s");
        ti    = same_str(t0, tl, ",i");
        tii   = same_str(t0, tl, ",ii");
        tiii  = same_str(t0, tl, ",iii");
        spec  = tl == SPECTRUM_BANDS + 1;
        for (int i = 1; spec && i < tl; i++)
            if (pkt_mem[t0 + i] != CH_F) spec = 0;
        skip = dev ? rl - 1 : 0;

        // layout mode takes priority, prefix stripped
        if (cfg_layout && (tf || tff) && slash) begin
            m.has_addr = 1; m.addr0 = a0 + skip; m.addrlen = al - skip;
            return float_class(m, MT_LAYOUT, off, tff ? 2 : 1);
        end
        if (cfg_layout && ts && slash) begin
            m.mtype = MT_LAYOUT_TXT;
            m.has_addr = 1; m.addr0 = a0 + skip; m.addrlen = al - skip;
            m.has_text = 1;
            return scan_str(off, m.text0, m.textlen);
        end
        // built-in endpoints
        if (dev && tff && same_str(ep, el, "xy0")) return float_class(m, MT_XY, off, 2);
        if (dev && tf && el == 6 && same_str(ep, 5, "fader") &&
            pkt_mem[ep + 5] >= CH_0 && pkt_mem[ep + 5] <= CH_3) begin
            m.idx = pkt_mem[ep + 5] - CH_0;
            return float_class(m, MT_FADER, off, 1);
        end
        if (dev && ti && el == 7 && same_str(ep, 6, "button") &&
            pkt_mem[ep + 6] >= CH_0 && pkt_mem[ep + 6] <= CH_3) begin
            m.mtype = MT_BUTTON;
            m.idx = pkt_mem[ep + 6] - CH_0;
            if (!fetch_word(off, w) || w > 1) return 0;
            m.ival = w;
            return 1;
        end
        if (dev && (tii || tiii) && same_str(ep, el, "note")) begin
            m.mtype = MT_NOTE;
            if (!fetch_word(off, mn) || !fetch_word(off + 4, w) || mn > 127 || w > 1)
                return 0;
            if (tiii && (!fetch_word(off + 8, v) || v > 127)) return 0;
            m.idx = mn;
            m.ival = w;
            return 1;
        end
        if (dev && spec && same_str(ep, el, "spectrum0"))
            return float_class(m, MT_SPECTRUM, off, SPECTRUM_BANDS);
        if (dev && tiii && same_str(ep, el, "background")) begin
            m.mtype = MT_BACKGROUND;
            if (!fetch_word(off, m.red) || m.red > 255) return 0;
            if (!fetch_word(off + 4, m.green) || m.green > 255) return 0;
            if (!fetch_word(off + 8, m.blue) || m.blue > 255) return 0;
            return 1;
        end
        // plain layout addresses
        if ((tf || tff) && slash) begin
            m.has_addr = 1; m.addr0 = a0; m.addrlen = al;
            return float_class(m, MT_LAYOUT, off, tff ? 2 : 1);
        end
        if (ts && slash) begin
            m.mtype = MT_LAYOUT_TXT;
            m.has_addr = 1; m.addr0 = a0; m.addrlen = al;
            m.has_text = 1;
            return scan_str(off, m.text0, m.textlen);
        end
        return 0;
    endfunction

    // Address or text split into eight-character beats
    function automatic void add_chunks(ref t_result rows[$], input t_kind k,
                                       input int unsigned st, len);
        t_result r;
        int unsigned cnt;
        for (int unsigned p = 0; p < len; p += 8) begin
            if (rows.size() >= MAX_RESULTS) return;
            r = '0;
            r.kind = k;
            cnt = (len - p < 8) ? len - p : 8;
            for (int j = 0; j < cnt; j++)
                r.payload[63 - 8 * j -: 8] = pkt_mem[st + p + j];
            r.payload_bytes = cnt[3:0];
            rows.push_back(r);
        end
    endfunction

    function automatic void predict_packet();
        msg_info_t   m;
        t_result     r;
        t_result     rows[$];
        bit          ok;
        int unsigned w;
        ok = classify(m);
        r = '0;
        r.kind = KIND_VERDICT;
        if (ok) begin
            r.accepted     = 1'b1;
            r.message_type = m.mtype;
            r.index        = m.idx[6:0];
            r.int_value    = m.ival[0];
            r.value_count  = m.cnt[5:0];
            r.red          = m.red[7:0];
            r.green        = m.green[7:0];
            r.blue         = m.blue[7:0];
        end
        rows.push_back(r);
        if (ok) begin
            for (int i = 0; i < m.cnt && rows.size() < MAX_RESULTS; i++) begin
                r = '0;
                r.kind = KIND_FLOAT;
                void'(fetch_word(m.fpos + 4 * i, w));
                r.payload = {32'd0, w};
                rows.push_back(r);
            end
            if (m.has_addr) add_chunks(rows, KIND_ADDR, m.addr0, m.addrlen);
            if (m.has_text) add_chunks(rows, KIND_TEXT, m.text0, m.textlen);
        end
        rows[rows.size() - 1].last = 1'b1;
        foreach (rows[i]) beats_due.push_back(rows[i]);
    endfunction

    function automatic void take_byte(logic [7:0] b, logic eop);
        if (pkt_fill < PACKET_BYTES) begin
            pkt_mem[pkt_fill] = b;
            pkt_fill++;
        end
        if (eop) begin
            pkt_len  = pkt_fill;
            pkt_fill = 0;
            predict_packet();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
        $display("[%0t] MISMATCH %s: got %h expected %h", $time, what, got, exp);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_beats++;
            if (beats_due.size() == 0) begin
                report_mismatch("beat with nothing expected", o_payload, 64'd0);
            end else begin
                beat_exp = beats_due.pop_front();
                if (o_kind !== beat_exp.kind)
                    report_mismatch("kind", o_kind, beat_exp.kind);
                if (o_accepted !== beat_exp.accepted)
                    report_mismatch("accepted", o_accepted, beat_exp.accepted);
                if (o_message_type !== beat_exp.message_type)
                    report_mismatch("message_type", o_message_type, beat_exp.message_type);
                if (o_index !== beat_exp.index)
                    report_mismatch("index", o_index, beat_exp.index);
                if (o_int_value !== beat_exp.int_value)
                    report_mismatch("int_value", o_int_value, beat_exp.int_value);
                if (o_value_count !== beat_exp.value_count)
                    report_mismatch("value_count", o_value_count, beat_exp.value_count);
                if (o_red !== beat_exp.red)
                    report_mismatch("red", o_red, beat_exp.red);
                if (o_green !== beat_exp.green)
                    report_mismatch("green", o_green, beat_exp.green);
                if (o_blue !== beat_exp.blue)
                    report_mismatch("blue", o_blue, beat_exp.blue);
                if (o_payload !== beat_exp.payload)
                    report_mismatch("payload", o_payload, beat_exp.payload);
                if (o_payload_bytes !== beat_exp.payload_bytes)
                    report_mismatch("payload_bytes", o_payload_bytes, beat_exp.payload_bytes);
                if (o_last !== beat_exp.last)
                    report_mismatch("last", o_last, beat_exp.last);
                if (beat_exp.kind == KIND_VERDICT && beat_exp.accepted) n_accepted++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // One byte beat; entered and left at a rising edge
    task automatic send_beat(logic [7:0] b, logic eop);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_packet_byte   <= b;
        i_end_of_packet <= eop;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        take_byte(b, eop);
        n_bytes++;
    endtask

    task automatic send_packet();
        foreach (pk[i]) send_beat(pk[i], i == pk.size() - 1);
        n_packets++;
    endtask

    // Wait for every expected beat, then let the block go quiet
    task automatic settle(int extra);
        start <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_beat(t_cfg_idx idx, logic [63:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        case (idx)
            CFG_LAYOUT_MODE: cfg_layout = d[0];
            CFG_NAME_FIRST:  cfg_first  = d;
            CFG_NAME_SECOND: cfg_second = d;
            CFG_NAME_LENGTH: cfg_len    = d[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic lm, logic [63:0] f, logic [63:0] s, logic [4:0] len);
        settle(SETTLE_CYCLES);
        cfg_beat(CFG_LAYOUT_MODE, {63'd0, lm});
        cfg_beat(CFG_NAME_FIRST, f);
        cfg_beat(CFG_NAME_SECOND, s);
        cfg_beat(CFG_NAME_LENGTH, {59'd0, len});
        i_cfg_valid <= 1'b0;
        n_configs++;
    endtask

    // ------------------------------------------------------------------
    // Packet building
    // ------------------------------------------------------------------
    function automatic void pk_chars(string s);
        for (int i = 0; i < s.len(); i++) pk.push_back(s[i]);
    endfunction

    function automatic void pk_term();
        pk.push_back(CH_NUL);
        while (pk.size() % 4 != 0) pk.push_back(CH_NUL);
    endfunction

    function automatic void pk_word(logic [31:0] w);
        pk.push_back(w[31:24]); pk.push_back(w[23:16]);
        pk.push_back(w[15:8]);  pk.push_back(w[7:0]);
    endfunction

    function automatic void pk_prefix();
        int unsigned nl;
        nl = (cfg_len > NAME_CHARS) ? NAME_CHARS : cfg_len;
        pk.push_back(CH_SLASH);
        for (int i = 0; i < nl; i++) pk.push_back(name_chr(i));
        pk.push_back(CH_SLASH);
    endfunction

    // Endpoint under the device prefix, then the type tags
    function automatic void pk_dev(string ep, string tags);
        pk.delete();
        pk_prefix();
        pk_chars(ep);
        pk_term();
        pk_chars(tags);
        pk_term();
    endfunction

    function automatic void pk_rand_chars(int n);
        repeat (n) pk.push_back($urandom_range(1, 255));
    endfunction

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 9))
            0:       return FLOAT_NEG_ZERO;
            1:       return FLOAT_ONE;
            2:       return $urandom;
            3:       return FLOAT_ONE + 32'd1;
            default: return $urandom_range(0, FLOAT_ONE);
        endcase
    endfunction

    function automatic logic [31:0] rand_small(int hi);
        return ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, hi);
    endfunction

    function automatic void build_packet(int cls);
        bit two;
        pk.delete();
        two = $urandom_range(0, 1);
        case (cls)
            0, 1: begin
                // free layout address, with or without device prefix
                if ($urandom_range(0, 1)) pk_prefix();
                else pk.push_back(CH_SLASH);
                pk_rand_chars($urandom_range(0, 14));
                pk_term();
                if (cls == 0) begin
                    pk_chars(two ? ",ff" : ",f");
                    pk_term();
                    pk_word(rand_float());
                    if (two) pk_word(rand_float());
                end else begin
                    pk_chars(",s");
                    pk_term();
                    pk_rand_chars($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
                    pk_term();
                end
            end
            2: begin
                pk_dev("xy0", $urandom_range(0, 4) ? ",ff" : ",f");
                pk_word(rand_float());
                pk_word(rand_float());
            end
            3: begin
                pk_dev($sformatf("fader%0d", $urandom_range(0, 4)), ",f");
                pk_word(rand_float());
            end
            4: begin
                pk_dev($sformatf("button%0d", $urandom_range(0, 4)), ",i");
                pk_word(rand_small(2));
            end
            5: begin
                pk_dev("note", two ? ",iii" : ",ii");
                pk_word(rand_small(130));
                pk_word(rand_small(2));
                if (two) pk_word(rand_small(130));
            end
            6: begin
                pk.delete();
                pk_prefix();
                pk_chars("spectrum0");
                pk_term();
                pk.push_back(CH_COMMA);
                repeat ($urandom_range(0, 3) ? SPECTRUM_BANDS : SPECTRUM_BANDS - 1)
                    pk.push_back(CH_F);
                pk_term();
                repeat (SPECTRUM_BANDS) pk_word($urandom_range(0, 7) ? 
                    $urandom_range(0, FLOAT_ONE) : rand_float());
            end
            7: begin
                pk_dev("background", ",iii");
                repeat (3) pk_word(rand_small(260));
            end
            default: begin
                // noise, zero bytes favoured so strings terminate
                repeat ($urandom_range(1, 40))
                    pk.push_back($urandom_range(0, 2) == 0 ? CH_NUL : $urandom_range(0, 255));
            end
        endcase
        // broken sequences: truncation or a corrupted byte
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 8)) if (pk.size() > 1) void'(pk.pop_back());
            end else begin
                pk[$urandom_range(0, pk.size() - 1)] = $urandom_range(0, 255);
            end
        end
    endfunction

    function automatic int pick_class();
        if ($urandom_range(0, 40) == 0) return 6;
        case ($urandom_range(0, 8))
            0: return 0;  1: return 1;  2: return 2;  3: return 3;
            4: return 4;  5: return 5;  6: return 7;  7: return 0;
            default: return 8;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values: layout off, empty device name, so the prefix is "//"
    task automatic test_reset_values();
        pk_dev("fader2", ",f");
        pk_word(32'h3F00_0000);
        send_packet();
        pk_dev("note", ",ii");
        pk_word(32'd127);
        pk_word(32'd1);
        send_packet();
    endtask

    // One of each built-in endpoint, a layout text message and the range edges
    task automatic test_classes();
        set_config(1'b0, {"dev", 40'd0}, 64'd0, 5'd3);
        pk_dev("xy0", ",ff");
        pk_word(FLOAT_ONE);
        pk_word(FLOAT_NEG_ZERO);
        send_packet();
        pk_dev("fader3", ",f");
        pk_word(32'd0);
        send_packet();
        pk_dev("button0", ",i");
        pk_word(32'd1);
        send_packet();
        pk_dev("note", ",iii");
        pk_word(32'd0);
        pk_word(32'd0);
        pk_word(32'd127);
        send_packet();
        pk_dev("background", ",iii");
        pk_word(32'd255);
        pk_word(32'd0);
        pk_word(32'd128);
        send_packet();
        build_packet(6);
        send_packet();
        pk.delete();
        pk_chars("/some/long/layout/address");
        pk_term();
        pk_chars(",s");
        pk_term();
        pk_chars("hello text");
        pk_term();
        send_packet();
    endtask

    // Rejections, empty text, short and overlong packets
    task automatic test_special_cases();
        pk_dev("fader1", ",f");
        pk_word(FLOAT_ONE + 32'd1);
        send_packet();
        pk_dev("button4", ",i");
        pk_word(32'd0);
        send_packet();
        pk_dev("note", ",ii");
        pk_word(32'd128);
        pk_word(32'd0);
        send_packet();
        pk.delete();
        pk_chars("/t");
        pk_term();
        pk_chars(",s");
        pk_term();
        pk_term();
        send_packet();
        // missing comma in the tags
        pk.delete();
        pk_chars("/x");
        pk_term();
        pk_chars("ff");
        pk_term();
        send_packet();
        pk.delete();
        pk.push_back(8'hFF);
        send_packet();
        // overlong: valid message, tail beyond the store dropped
        pk.delete();
        pk_chars("/over");
        pk_term();
        pk_chars(",f");
        pk_term();
        pk_word(32'h3E80_0000);
        while (pk.size() < PACKET_BYTES + 4) pk.push_back($urandom_range(0, 255));
        send_packet();
    endtask

    // Layout mode strips the prefix and wins over built-in endpoints
    task automatic test_layout_mode();
        set_config(1'b1, {"dev", 40'd0}, 64'd0, 5'd3);
        pk_dev("xy0", ",ff");
        pk_word(32'h3F00_0000);
        pk_word(32'h3E00_0000);
        send_packet();
        pk_dev("label1", ",s");
        pk_chars("layout text here");
        pk_term();
        send_packet();
        pk_dev("note", ",ii");
        pk_word(32'd60);
        pk_word(32'd1);
        send_packet();
    endtask

    // Longest name, length above the limit, all-ones and empty name
    task automatic test_name_extremes();
        set_config(1'b0, "ABCDEFGH", "IJKLMNOP", 5'd16);
        for (int c = 2; c <= 7; c++) begin
            build_packet(c);
            send_packet();
        end
        set_config(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
        for (int c = 0; c <= 4; c++) begin
            build_packet(c);
            send_packet();
        end
        set_config(1'b0, 64'd0, 64'd0, 5'd0);
        build_packet(3);
        send_packet();
    endtask

    task automatic test_random();
        int pkts, bytes0;
        pkts = 0;
        bytes0 = n_bytes;
        while (n_bytes - bytes0 < RANDOM_BYTES || pkts < RANDOM_PKTS) begin
            if (pkts % 12 == 0)
                set_config($urandom_range(0, 1), {$urandom, $urandom}, {$urandom, $urandom},
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 8));
            else if (pkts % 7 == 3)
                settle(0);
            burst = $urandom_range(0, 3) == 0;
            build_packet(pick_class());
            send_packet();
            pkts++;
        end
        burst = 0;
    endtask

    initial begin
        n_errors = 0; n_packets = 0; n_bytes = 0; n_beats = 0;
        n_accepted = 0; n_configs = 0; cycles = 0; burst = 0;
        cfg_layout = 0; cfg_first = '0; cfg_second = '0; cfg_len = '0;
        pkt_fill = 0; pkt_len = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_classes();
        test_special_cases();
        test_layout_mode();
        test_name_extremes();
        test_random();

        settle(TAIL_CYCLES);
        $display("Covered %0d packets (%0d bytes) over %0d register settings",
                 n_packets, n_bytes, n_configs);
        $display("Checked %0d result beats, %0d accepted messages", n_beats, n_accepted);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
